### sv/ddo_pkg.sv
// Shared types, constants and tables for the differential drive odometry core.
package ddo_pkg;

    // Shared multiplier operand and accumulator widths
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 112;

    // Trig outputs are signed Q1.30 carried in 33 bits
    localparam int TRIG_W = 33;

    // CORDIC
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_IDX_W = $clog2(CORDIC_STEPS);
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sh026DD3B6A;

    // 2^64 / (2*pi): radians to binary angle
    localparam logic [63:0] TURN_PER_RAD = 64'h28BE_60DB_9391_054A;

    // Accumulator alignment codes: product placed at word 0..3 (32-bit words)
    localparam logic [1:0] MAC_SH0 = 2'd0;
    localparam logic [1:0] MAC_SH1 = 2'd1;
    localparam logic [1:0] MAC_SH2 = 2'd2;
    localparam logic [1:0] MAC_SH3 = 2'd3;

    typedef struct packed {
        logic       issue;
        logic       clear;
        logic [1:0] shift;
    } mac_op_t;

    // atan(2^-i) as binary angle (2^32 per turn)
    function automatic logic signed [31:0] atan_bam(input logic [CORDIC_IDX_W-1:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd536870912;
            5'd1:    v = 32'sd316933406;
            5'd2:    v = 32'sd167458907;
            5'd3:    v = 32'sd85004756;
            5'd4:    v = 32'sd42667331;
            5'd5:    v = 32'sd21354465;
            5'd6:    v = 32'sd10679838;
            5'd7:    v = 32'sd5340245;
            5'd8:    v = 32'sd2670163;
            5'd9:    v = 32'sd1335087;
            5'd10:   v = 32'sd667544;
            5'd11:   v = 32'sd333772;
            5'd12:   v = 32'sd166886;
            5'd13:   v = 32'sd83443;
            5'd14:   v = 32'sd41722;
            5'd15:   v = 32'sd20861;
            5'd16:   v = 32'sd10430;
            5'd17:   v = 32'sd5215;
            5'd18:   v = 32'sd2608;
            5'd19:   v = 32'sd1304;
            5'd20:   v = 32'sd652;
            5'd21:   v = 32'sd326;
            5'd22:   v = 32'sd163;
            5'd23:   v = 32'sd81;
            5'd24:   v = 32'sd41;
            5'd25:   v = 32'sd20;
            5'd26:   v = 32'sd10;
            5'd27:   v = 32'sd5;
            5'd28:   v = 32'sd3;
            5'd29:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

### sv/ddo_mac.sv
// Shared 33x33 signed multiplier with a registered, word-aligned 112-bit accumulator.
module ddo_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ddo_pkg::mac_op_t                  op,
    input  logic signed [ddo_pkg::MUL_W-1:0]  a,
    input  logic signed [ddo_pkg::MUL_W-1:0]  b,
    output logic signed [ddo_pkg::PROD_W-1:0] prod,
    output logic [ddo_pkg::ACC_W-1:0]         acc
);
    import ddo_pkg::*;

    mac_op_t                  op_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         ext;
    logic [ACC_W-1:0]         aligned;
    logic [ACC_W-1:0]         acc_next;

    // stage 1: multiply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= '0;
        end
        else
        begin
            op_reg <= op;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.issue)
        begin
            prod_reg <= a * b;
        end
    end

    // stage 2: align and accumulate (mod 2^112)
    always_comb
    begin
        ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        case (op_reg.shift)
            MAC_SH0: aligned = ext;
            MAC_SH1: aligned = {ext[ACC_W-33:0], 32'b0};
            MAC_SH2: aligned = {ext[ACC_W-65:0], 64'b0};
            MAC_SH3: aligned = {ext[ACC_W-97:0], 96'b0};
            default: aligned = ext;
        endcase
        acc_next = (op_reg.clear ? '0 : acc_reg) + aligned;
    end

    always_ff @(posedge clk)
    begin
        if (op_reg.issue)
        begin
            acc_reg <= acc_next;
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

### sv/ddo_cordic.sv
// Iterative rotation-mode CORDIC: binary angle in, Q1.30 cos and sin out.
module ddo_cordic (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [31:0]                        angle,
    output logic                               done,
    output logic signed [ddo_pkg::TRIG_W-1:0]  cos_val,
    output logic signed [ddo_pkg::TRIG_W-1:0]  sin_val
);
    import ddo_pkg::*;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic signed [TRIG_W-1:0] x_reg, y_reg, x_next, y_next, xs, ys;
    logic signed [31:0]       z_reg, z_next, at;
    logic [CORDIC_IDX_W-1:0]  i_reg;
    logic [1:0]               q_reg;
    logic                     run_reg, done_reg;
    logic [31:0]              biased;
    logic [1:0]               q_start;
    logic [31:0]              z_start;

    // quadrant fold: CORDIC only sees angles within an eighth turn of zero
    always_comb
    begin
        biased  = angle + 32'h2000_0000;
        q_start = biased[31:30];
        z_start = angle - {q_start, 30'b0};
    end

    always_comb
    begin
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        at = atan_bam(i_reg);
        if (!z_reg[31])
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                i_reg   <= '0;
            end
            else if (run_reg)
            begin
                i_reg <= i_reg + 1'b1;
                if (i_reg == CORDIC_IDX_W'(CORDIC_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= CORDIC_GAIN;
            y_reg <= '0;
            z_reg <= z_start;
            q_reg <= q_start;
        end
        else if (run_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    always_comb
    begin
        case (q_reg)
            QUAD_0:
            begin
                cos_val = x_reg;
                sin_val = y_reg;
            end
            QUAD_1:
            begin
                cos_val = -y_reg;
                sin_val = x_reg;
            end
            QUAD_2:
            begin
                cos_val = -x_reg;
                sin_val = -y_reg;
            end
            default:
            begin
                cos_val = y_reg;
                sin_val = -x_reg;
            end
        endcase
    end

    assign done = done_reg;

endmodule

### sv/differential_drive_odometry_core.sv
// Top level of the differential drive dead-reckoning odometry core.
//
//  channel   handshake             payload
//  -------   -------------------   ------------------------------------------------
//  in        in_valid / in_ready   kind, left_count, right_count, new_x, new_y,
//                                  new_heading
//  out       out_valid/ out_ready  pose_x, pose_y, pose_heading
//  cfg       cfg_we (no wait)      cfg_index, cfg_data (0 mm_per_tick, 1 inv_track_width)
//
// An encoder sample runs 15 multiplies on the one shared 33x33 multiplier (wheel
// distances, heading change, two displacements) plus 30 CORDIC iterations on the
// CORDIC's own shift-add unit. A set-pose item goes from idle straight to the commit.
// in_ready is high only while the sequencer is idle; one item is in work at a time.
// The result register holds the pose; a new item is taken while it waits, and the next
// commit stalls until it is taken.
// Reset (rst_n, async low) clears pose, reference counts and both registers to zero.
module differential_drive_odometry_core (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic signed [31:0] left_count,
    input  logic signed [31:0] right_count,
    input  logic signed [47:0] new_x,
    input  logic signed [47:0] new_y,
    input  logic [31:0]        new_heading,

    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [47:0] pose_x,
    output logic signed [47:0] pose_y,
    output logic [31:0]        pose_heading,

    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data
);
    import ddo_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WHEEL = 4'd1;   // left/right count deltas times mm_per_tick
    localparam logic [3:0] S_MIX   = 4'd2;   // forward step and wheel difference
    localparam logic [3:0] S_TURN1 = 4'd3;   // diff * inv_track_width
    localparam logic [3:0] S_TURN2 = 4'd4;   // times 2^64/(2pi), 7 partial products
    localparam logic [3:0] S_HEAD  = 4'd5;   // new heading
    localparam logic [3:0] S_ROT   = 4'd6;   // CORDIC
    localparam logic [3:0] S_MOVE  = 4'd7;   // step*cos, step*sin
    localparam logic [3:0] S_POSE  = 4'd8;   // commit pose and present result

    localparam logic       REG_MM_PER_TICK = 1'b0;
    localparam logic       REG_INV_TRACK   = 1'b1;

    // displacement clamp (+-2^48) and 48-bit position limits
    localparam logic signed [81:0] MOVE_MAX = 82'sh1_0000_0000_0000;
    localparam logic signed [81:0] MOVE_MIN = -MOVE_MAX;
    localparam logic signed [50:0] POS_MAX_W = 51'sd140737488355327;
    localparam logic signed [50:0] POS_MIN_W = -51'sd140737488355328;

    function automatic logic signed [55:0] wheel_round(input logic [PROD_W-1:0] p);
        logic [63:0] r;
        r = p[63:0] + 64'd128;   // round half up from Q.24 to Q.16
        return r[63:8];
    endfunction

    function automatic logic signed [49:0] clamp_move(input logic [ACC_W-1:0] a);
        logic signed [81:0] mv;
        logic signed [49:0] r;
        mv = a[ACC_W-1:30];      // floor(product / 2^30)
        if (mv > MOVE_MAX)
        begin
            r = MOVE_MAX[49:0];
        end
        else if (mv < MOVE_MIN)
        begin
            r = MOVE_MIN[49:0];
        end
        else
        begin
            r = mv[49:0];
        end
        return r;
    endfunction

    function automatic logic signed [47:0] sat_pos(input logic signed [47:0] p,
                                                   input logic signed [49:0] d);
        logic signed [50:0] s;
        logic signed [47:0] r;
        s = {{3{p[47]}}, p} + {d[49], d};
        if (s > POS_MAX_W)
        begin
            r = POS_MAX_W[47:0];
        end
        else if (s < POS_MIN_W)
        begin
            r = POS_MIN_W[47:0];
        end
        else
        begin
            r = s[47:0];
        end
        return r;
    endfunction

    // control and architectural state
    logic [3:0]         state_reg, state_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               out_valid_reg;
    logic [31:0]        mpt_reg, itw_reg;
    logic [31:0]        prev_left_reg, prev_right_reg;
    logic signed [47:0] pos_x_reg, pos_y_reg;
    logic [31:0]        heading_reg;

    // per-item working registers
    logic               kind_reg;
    logic [31:0]        lc_reg, rc_reg;
    logic signed [47:0] nx_reg, ny_reg;
    logic [31:0]        hnew_reg;
    logic signed [55:0] sl_reg, sr_reg, step_reg;
    logic signed [56:0] diff_reg;
    logic [ACC_W-1:0]   p_reg;
    logic signed [49:0] dx_reg, dy_reg;

    logic               accept, commit;
    logic [31:0]        dl, dr;
    logic signed [56:0] wsum;

    mac_op_t                  mac_op;
    logic signed [MUL_W-1:0]  mac_a, mac_b;
    logic signed [PROD_W-1:0] mac_prod;
    logic [ACC_W-1:0]         mac_acc;

    logic                     cord_start, cord_done;
    logic signed [TRIG_W-1:0] cos_val, sin_val;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign commit   = (state_reg == S_POSE) && (!out_valid_reg || out_ready);

    assign dl = lc_reg - prev_left_reg;     // modular count difference
    assign dr = rc_reg - prev_right_reg;
    assign wsum = {sl_reg[55], sl_reg} + {sr_reg[55], sr_reg};

    assign cord_start = (state_reg == S_ROT) && (cnt_reg == 3'd0);

    ddo_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .a     (mac_a),
        .b     (mac_b),
        .prod  (mac_prod),
        .acc   (mac_acc)
    );

    ddo_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start),
        .angle   (hnew_reg),
        .done    (cord_done),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    // Multiplier schedule. Products come the cycle after issue, the accumulator the cycle
    // after that. Low words zero-extended; wheel deltas and top words of diff and step sign-extended.
    always_comb
    begin
        mac_op = '{issue: 1'b0, clear: 1'b0, shift: MAC_SH0};
        mac_a  = '0;
        mac_b  = '0;
        case (state_reg)
            S_WHEEL:
            begin
                if (cnt_reg == 3'd0)
                begin
                    mac_op = '{issue: 1'b1, clear: 1'b1, shift: MAC_SH0};
                    mac_a  = {dl[31], dl};
                    mac_b  = {1'b0, mpt_reg};
                end
                else if (cnt_reg == 3'd1)
                begin
                    mac_op = '{issue: 1'b1, clear: 1'b1, shift: MAC_SH0};
                    mac_a  = {dr[31], dr};
                    mac_b  = {1'b0, mpt_reg};
                end
            end
            S_TURN1:
            begin
                mac_b = {1'b0, itw_reg};
                if (cnt_reg == 3'd0)
                begin
                    mac_op = '{issue: 1'b1, clear: 1'b1, shift: MAC_SH0};
                    mac_a  = {1'b0, diff_reg[31:0]};
                end
                else if (cnt_reg == 3'd1)
                begin
                    mac_op = '{issue: 1'b1, clear: 1'b0, shift: MAC_SH1};
                    mac_a  = {{8{diff_reg[56]}}, diff_reg[56:32]};
                end
            end
            S_TURN2:
            begin
                // only bits 80..111 of the product are kept, so terms above word 3 drop
                case (cnt_reg)
                    3'd0:
                    begin
                        mac_op = '{issue: 1'b1, clear: 1'b1, shift: MAC_SH0};
                        mac_a  = {1'b0, p_reg[31:0]};
                        mac_b  = {1'b0, TURN_PER_RAD[31:0]};
                    end
                    3'd1:
                    begin
                        mac_op = '{issue: 1'b1, clear: 1'b0, shift: MAC_SH1};
                        mac_a  = {1'b0, p_reg[31:0]};
                        mac_b  = {1'b0, TURN_PER_RAD[63:32]};
                    end
                    3'd2:
                    begin
                        mac_op = '{issue: 1'b1, clear: 1'b0, shift: MAC_SH1};
                        mac_a  = {1'b0, p_reg[63:32]};
                        mac_b  = {1'b0, TURN_PER_RAD[31:0]};
                    end
                    3'd3:
                    begin
                        mac_op = '{issue: 1'b1, clear: 1'b0, shift: MAC_SH2};
                        mac_a  = {1'b0, p_reg[63:32]};
                        mac_b  = {1'b0, TURN_PER_RAD[63:32]};
                    end
                    3'd4:
                    begin
                        mac_op = '{issue: 1'b1, clear: 1'b0, shift: MAC_SH2};
                        mac_a  = {1'b0, p_reg[95:64]};
                        mac_b  = {1'b0, TURN_PER_RAD[31:0]};
                    end
                    3'd5:
                    begin
                        mac_op = '{issue: 1'b1, clear: 1'b0, shift: MAC_SH3};
                        mac_a  = {1'b0, p_reg[95:64]};
                        mac_b  = {1'b0, TURN_PER_RAD[63:32]};
                    end
                    3'd6:
                    begin
                        mac_op = '{issue: 1'b1, clear: 1'b0, shift: MAC_SH3};
                        mac_a  = {17'b0, p_reg[111:96]};
                        mac_b  = {1'b0, TURN_PER_RAD[31:0]};
                    end
                    default:
                    begin
                        mac_op = '{issue: 1'b0, clear: 1'b0, shift: MAC_SH0};
                    end
                endcase
            end
            S_MOVE:
            begin
                case (cnt_reg)
                    3'd0:
                    begin
                        mac_op = '{issue: 1'b1, clear: 1'b1, shift: MAC_SH0};
                        mac_a  = {1'b0, step_reg[31:0]};
                        mac_b  = cos_val;
                    end
                    3'd1:
                    begin
                        mac_op = '{issue: 1'b1, clear: 1'b0, shift: MAC_SH1};
                        mac_a  = {{9{step_reg[55]}}, step_reg[55:32]};
                        mac_b  = cos_val;
                    end
                    3'd2:
                    begin
                        mac_op = '{issue: 1'b1, clear: 1'b1, shift: MAC_SH0};
                        mac_a  = {1'b0, step_reg[31:0]};
                        mac_b  = sin_val;
                    end
                    3'd3:
                    begin
                        mac_op = '{issue: 1'b1, clear: 1'b0, shift: MAC_SH1};
                        mac_a  = {{9{step_reg[55]}}, step_reg[55:32]};
                        mac_b  = sin_val;
                    end
                    default:
                    begin
                        mac_op = '{issue: 1'b0, clear: 1'b0, shift: MAC_SH0};
                    end
                endcase
            end
            default:
            begin
                mac_op = '{issue: 1'b0, clear: 1'b0, shift: MAC_SH0};
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 3'd1;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = kind ? S_POSE : S_WHEEL;
                end
            end
            S_WHEEL:
            begin
                if (cnt_reg == 3'd2)
                begin
                    state_next = S_MIX;
                    cnt_next   = '0;
                end
            end
            S_MIX:
            begin
                state_next = S_TURN1;
                cnt_next   = '0;
            end
            S_TURN1:
            begin
                if (cnt_reg == 3'd3)
                begin
                    state_next = S_TURN2;
                    cnt_next   = '0;
                end
            end
            S_TURN2:
            begin
                if (cnt_reg == 3'd7)
                begin
                    state_next = S_HEAD;
                    cnt_next   = '0;
                end
            end
            S_HEAD:
            begin
                state_next = S_ROT;
                cnt_next   = '0;
            end
            S_ROT:
            begin
                cnt_next = 3'd1;
                if (cord_done)
                begin
                    state_next = S_MOVE;
                    cnt_next   = '0;
                end
            end
            S_MOVE:
            begin
                if (cnt_reg == 3'd5)
                begin
                    state_next = S_POSE;
                    cnt_next   = '0;
                end
            end
            S_POSE:
            begin
                cnt_next = '0;
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            mpt_reg        <= '0;
            itw_reg        <= '0;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            heading_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MM_PER_TICK: mpt_reg <= cfg_data;
                    REG_INV_TRACK:   itw_reg <= cfg_data;
                    default:         mpt_reg <= mpt_reg;
                endcase
            end

            if (commit)
            begin
                out_valid_reg  <= 1'b1;
                prev_left_reg  <= lc_reg;
                prev_right_reg <= rc_reg;
                heading_reg    <= hnew_reg;
                if (kind_reg)
                begin
                    pos_x_reg <= nx_reg;
                    pos_y_reg <= ny_reg;
                end
                else
                begin
                    pos_x_reg <= sat_pos(pos_x_reg, dx_reg);
                    pos_y_reg <= sat_pos(pos_y_reg, dy_reg);
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            lc_reg   <= left_count;
            rc_reg   <= right_count;
            nx_reg   <= new_x;
            ny_reg   <= new_y;
            hnew_reg <= new_heading;   // set pose heading; overwritten for samples
        end
        if (state_reg == S_WHEEL && cnt_reg == 3'd1)
        begin
            sl_reg <= wheel_round(mac_prod);
        end
        if (state_reg == S_WHEEL && cnt_reg == 3'd2)
        begin
            sr_reg <= wheel_round(mac_prod);
        end
        if (state_reg == S_MIX)
        begin
            step_reg <= wsum[56:1];                                // floor of the mean
            diff_reg <= {sr_reg[55], sr_reg} - {sl_reg[55], sl_reg};
        end
        if (state_reg == S_TURN1 && cnt_reg == 3'd3)
        begin
            p_reg <= mac_acc;
        end
        if (state_reg == S_HEAD)
        begin
            hnew_reg <= heading_reg + mac_acc[111:80];             // wraps at a full turn
        end
        if (state_reg == S_MOVE && cnt_reg == 3'd3)
        begin
            dx_reg <= clamp_move(mac_acc);
        end
        if (state_reg == S_MOVE && cnt_reg == 3'd5)
        begin
            dy_reg <= clamp_move(mac_acc);
        end
    end

    assign out_valid    = out_valid_reg;
    assign pose_x       = pos_x_reg;
    assign pose_y       = pos_y_reg;
    assign pose_heading = heading_reg;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after accepting an item");

    a_hold_pose_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POSE) && out_valid_reg && !out_ready
            |=> $stable(pos_x_reg) && $stable(pos_y_reg) && $stable(heading_reg))
        else $error("pose changed while previous result was not taken");

    a_cordic_done_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
        cord_done |-> (state_reg == S_ROT))
        else $error("CORDIC finished outside the rotation phase");

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_POSE))
        else $error("result raised without a pose commit");
`endif

endmodule
